[src/sdspi_pkg.sv]
`default_nettype none
package sdspi_pkg;
	localparam int BLOCK_BYTES_DEF = 512;
	localparam int WAKE_BYTES_DEF = 10;
	localparam logic [15:0] BUSY_LIMIT_RST = 16'd300;
	localparam logic [15:0] TOKEN_LIMIT_RST = 16'd300;
	localparam logic [7:0] RESP_LIMIT_RST = 8'd255;

	localparam logic [1:0] FUNC_INIT = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] REG_BUSY = 2'd0;
	localparam logic [1:0] REG_TOKEN = 2'd1;
	localparam logic [1:0] REG_RESP = 2'd2;

	localparam logic [5:0] OP_RESET_CARD = 6'd0;
	localparam logic [5:0] OP_IF_COND = 6'd8;
	localparam logic [5:0] OP_READ_ONE = 6'd17;
	localparam logic [5:0] OP_APP_INIT = 6'd41;
	localparam logic [5:0] OP_APP_PREFIX = 6'd55;
	localparam logic [5:0] OP_READ_OCR = 6'd58;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_V1 = 2'd1;
	localparam logic [1:0] KIND_V2 = 2'd2;
	localparam logic [1:0] KIND_HC = 2'd3;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_REJECT = 3'd1;
	localparam logic [2:0] ERR_TIMEOUT = 3'd2;
	localparam logic [2:0] ERR_TOKEN = 3'd3;
	localparam logic [2:0] ERR_RANGE = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAKE, PH_BUSY, PH_FRAME, PH_RESP, PH_ECHO, PH_OCR, PH_TOKEN, PH_DATA
	} phase_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       deselect;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       request_done;
		logic [2:0] error_code;
		logic [1:0] card_kind;
		logic [7:0] last_status;
	} result_t;

	typedef struct packed {
		logic [15:0] busy;
		logic [15:0] token;
		logic [7:0]  resp;
	} limits_t;
endpackage
`default_nettype wire

[src/sdspi_seq.sv]
`default_nettype none
module sdspi_seq #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
	parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [31:0]       block_number,
	input  wire logic [8:0]        window_offset,
	input  wire logic [9:0]        window_length,
	input  wire sdspi_pkg::limits_t lim,
	output sdspi_pkg::result_t     res
);
	import sdspi_pkg::*;

	localparam int IW = $clog2(BLOCK_BYTES + 3);
	localparam logic [IW-1:0] LAST_IDX = IW'(BLOCK_BYTES + 2);
	localparam logic [IW-1:0] WAKE_IDX = IW'(WAKE_BYTES);
	localparam logic [10:0] BLK = 11'(BLOCK_BYTES);

	phase_t ph_q, ph_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [16:0] poll_q, poll_d;
	logic [31:0] arg_q, arg_d;
	logic [5:0] code_q, code_d;
	logic [1:0] kind_q, kind_d;
	logic [7:0] resp_q, resp_d;
	logic [9:0] ws_q, ws_d, wn_q, wn_d;
	result_t r;

	logic [15:0] busy_lim;
	logic [7:0] resp_lim;
	logic [10:0] pos, wend;
	logic [7:0] fb;
	logic [2:0] fi;

	assign busy_lim = (lim.busy == 16'd0) ? 16'd1 : lim.busy;
	assign resp_lim = (lim.resp == 8'd0) ? 8'd1 : lim.resp;
	assign pos = 11'(idx_q) - 11'd1;
	assign wend = 11'(ws_q) + 11'(wn_q);
	assign fi = idx_q[2:0];

	always_comb begin
		case (fi)
			3'd1: fb = arg_q[31:24];
			3'd2: fb = arg_q[23:16];
			3'd3: fb = arg_q[15:8];
			3'd4: fb = arg_q[7:0];
			default: fb = (code_q == OP_RESET_CARD) ? 8'h95 :
				(code_q == OP_IF_COND) ? 8'h87 : 8'hFF;
		endcase
	end

	always_comb begin
		ph_d = ph_q; idx_d = idx_q; poll_d = poll_q; arg_d = arg_q; code_d = code_q;
		kind_d = kind_q; resp_d = resp_q; ws_d = ws_q; wn_d = wn_q;
		r = '0;
		r.tx_byte = 8'hFF;
		r.deselect = 1'b1;
		if (func == FUNC_INIT) begin
			resp_d = 8'd0;
			ph_d = PH_WAKE;
			idx_d = IW'(1);
		end else if (func == FUNC_READ) begin
			if (window_length == 10'd0) begin
				ph_d = PH_IDLE; r.request_done = 1'b1;
			end else if (11'(window_offset) + 11'(window_length) > BLK) begin
				ph_d = PH_IDLE; r.request_done = 1'b1; r.error_code = ERR_RANGE;
			end else begin
				ws_d = 10'(window_offset);
				wn_d = window_length;
				ph_d = PH_BUSY; code_d = OP_READ_ONE; poll_d = 17'd1;
				arg_d = (kind_q == KIND_HC) ? block_number : {block_number[22:0], 9'd0};
				r.deselect = 1'b0;
			end
		end else begin
			unique case (ph_q)
				PH_WAKE: begin
					if (idx_q < WAKE_IDX) begin
						idx_d = idx_q + IW'(1);
					end else begin
						ph_d = PH_BUSY; code_d = OP_RESET_CARD; arg_d = '0; poll_d = 17'd1;
						r.deselect = 1'b0;
					end
				end
				PH_BUSY: begin
					r.deselect = 1'b0;
					if (rx_byte == 8'hFF || poll_q >= 17'(busy_lim)) begin
						ph_d = PH_FRAME;
						r.tx_byte = 8'h40 | {2'b00, code_q};
						idx_d = IW'(1);
					end else begin
						poll_d = poll_q + 17'd1;
					end
				end
				PH_FRAME: begin
					r.deselect = 1'b0;
					if (idx_q < IW'(6)) begin
						r.tx_byte = fb;
						idx_d = idx_q + IW'(1);
					end else begin
						ph_d = PH_RESP; poll_d = 17'd1;
					end
				end
				PH_RESP: begin
					resp_d = rx_byte;
					r.deselect = 1'b0;
					if (!rx_byte[7] || poll_q >= 17'(resp_lim)) begin
						poll_d = 17'd1;
						ph_d = PH_BUSY;
						arg_d = '0;
						case (code_q)
							OP_RESET_CARD: begin
								if (rx_byte == 8'h01) begin
									code_d = OP_IF_COND; arg_d = 32'h1AA;
								end else begin
									code_d = OP_RESET_CARD;
								end
							end
							OP_IF_COND: begin
								if (rx_byte[2]) begin
									kind_d = KIND_V1; code_d = OP_APP_PREFIX;
								end else begin
									ph_d = PH_ECHO; idx_d = IW'(1); poll_d = poll_q; arg_d = arg_q;
								end
							end
							OP_APP_PREFIX: begin
								code_d = OP_APP_INIT;
								arg_d = (kind_q == KIND_V2) ? 32'h4000_0000 : 32'd0;
							end
							OP_APP_INIT: begin
								if (rx_byte != 8'd0) begin
									code_d = OP_APP_PREFIX;
								end else if (kind_q == KIND_V2) begin
									code_d = OP_READ_OCR;
								end else begin
									ph_d = PH_IDLE; poll_d = poll_q; arg_d = arg_q;
									r.deselect = 1'b1; r.request_done = 1'b1;
								end
							end
							OP_READ_OCR: begin
								ph_d = PH_OCR; idx_d = IW'(1); poll_d = poll_q; arg_d = arg_q;
							end
							default: begin
								arg_d = arg_q;
								if (rx_byte != 8'd0) begin
									ph_d = PH_IDLE; poll_d = poll_q;
									r.deselect = 1'b1; r.request_done = 1'b1;
									r.error_code = ERR_REJECT;
								end else begin
									ph_d = PH_TOKEN; poll_d = 17'd0;
								end
							end
						endcase
					end else begin
						poll_d = poll_q + 17'd1;
					end
				end
				PH_ECHO: begin
					resp_d = rx_byte;
					r.deselect = 1'b0;
					if (idx_q < IW'(4)) begin
						idx_d = idx_q + IW'(1);
					end else begin
						kind_d = KIND_V2;
						ph_d = PH_BUSY; code_d = OP_APP_PREFIX; arg_d = '0; poll_d = 17'd1;
					end
				end
				PH_OCR: begin
					if (idx_q == IW'(1) && rx_byte[7:6] == 2'b11) kind_d = KIND_HC;
					if (idx_q < IW'(4)) begin
						idx_d = idx_q + IW'(1);
						r.deselect = 1'b0;
					end else begin
						ph_d = PH_IDLE; r.request_done = 1'b1;
					end
				end
				PH_TOKEN: begin
					resp_d = rx_byte;
					if (rx_byte == 8'hFF) begin
						if (poll_q > 17'(lim.token)) begin
							ph_d = PH_IDLE; r.request_done = 1'b1; r.error_code = ERR_TIMEOUT;
						end else begin
							poll_d = poll_q + 17'd1; r.deselect = 1'b0;
						end
					end else if (rx_byte == 8'hFE) begin
						ph_d = PH_DATA; idx_d = IW'(1); r.deselect = 1'b0;
					end else begin
						ph_d = PH_IDLE; r.request_done = 1'b1; r.error_code = ERR_TOKEN;
					end
				end
				PH_DATA: begin
					if (pos >= 11'(ws_q) && pos < wend) begin
						r.data_valid = 1'b1; r.data_byte = rx_byte;
					end
					if (idx_q < LAST_IDX) begin
						idx_d = idx_q + IW'(1); r.deselect = 1'b0;
					end else begin
						ph_d = PH_IDLE; r.request_done = 1'b1;
					end
				end
				default: ph_d = PH_IDLE;
			endcase
		end
		r.card_kind = kind_d;
		r.last_status = resp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; idx_q <= '0; poll_q <= '0; arg_q <= '0; code_q <= '0;
			kind_q <= KIND_NONE; resp_q <= '0; ws_q <= '0; wn_q <= '0;
			res <= '0;
		end else if (step) begin
			ph_q <= ph_d; idx_q <= idx_d; poll_q <= poll_d; arg_q <= arg_d;
			code_q <= code_d; kind_q <= kind_d; resp_q <= resp_d; ws_q <= ws_d; wn_q <= wn_d;
			res <= r;
		end
	end
endmodule
`default_nettype wire

[src/sd_spi_init_and_block_read.sv]
// SD card SPI-mode host sequencer, one transaction per SPI byte exchange.
// Input channel (in_valid/in_stall): func selects a byte exchange (0 or 3),
// an init request (1) or a block read request (2) with block_number,
// window_offset and window_length. rx_byte is the byte the card returned
// for the previously issued tx_byte.
// Output channel (out_valid/out_stall): one result per input transaction:
// next tx_byte and deselect, an optional data byte, request_done,
// error_code, card_kind and last_status.
// out_valid rises in the cycle after acceptance. One transaction per cycle
// is sustained unless stalled; state update and result register form the
// only stage. in_stall is high only while a result is held and out_stall
// is high, so a stalled receiver blocks new input without losing results.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the poll limits.
// Reset returns to idle, card kind unknown, limits 300/300/255.
`default_nettype none
module sd_spi_init_and_block_read #(
	parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
	parameter int WAKE_BYTES = sdspi_pkg::WAKE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] block_number,
	input  wire logic [8:0]  window_offset,
	input  wire logic [9:0]  window_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       tx_byte,
	output logic             deselect,
	output logic             data_valid,
	output logic [7:0]       data_byte,
	output logic             request_done,
	output logic [2:0]       error_code,
	output logic [1:0]       card_kind,
	output logic [7:0]       last_status
);
	import sdspi_pkg::*;

	limits_t lim_q;
	result_t res;
	logic step;
	logic vld_q;

	assign in_stall = vld_q & out_stall;
	assign step = in_valid & ~in_stall;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '{busy: BUSY_LIMIT_RST, token: TOKEN_LIMIT_RST, resp: RESP_LIMIT_RST};
			vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BUSY: lim_q.busy <= cfg_data;
					REG_TOKEN: lim_q.token <= cfg_data;
					REG_RESP: lim_q.resp <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (step) vld_q <= 1'b1;
			else if (!out_stall) vld_q <= 1'b0;
		end
	end

	sdspi_seq #(.BLOCK_BYTES(BLOCK_BYTES), .WAKE_BYTES(WAKE_BYTES)) u_seq (
		.clk, .arst_n, .step, .func, .rx_byte, .block_number, .window_offset,
		.window_length, .lim(lim_q), .res
	);

	assign tx_byte = res.tx_byte;
	assign deselect = res.deselect;
	assign data_valid = res.data_valid;
	assign data_byte = res.data_byte;
	assign request_done = res.request_done;
	assign error_code = res.error_code;
	assign card_kind = res.card_kind;
	assign last_status = res.last_status;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_status))
		else $error("result changed under stall");
	a_done_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_done |-> deselect)
		else $error("done with card selected");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !request_done |-> error_code == ERR_OK)
		else $error("error without done");
	a_dv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == 8'd0)
		else $error("data byte without valid");
endmodule
`default_nettype wire
